// File: hw/rtl/rww_pkg.sv
// Shared constants and types for the range wrap weight block.
package rww_pkg;

   // Default value format and the fixed widths of the result fields.
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int WEIGHT_FRAC     = 16;
   localparam int WEIGHT_W        = 18;
   localparam int COUNT_W         = 16;
   localparam int COUNT_MAX       = 32767;
   localparam int MODE_W          = 3;
   localparam int CSR_INDEX_W     = 2;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = 18'sd65536;

   // Wrap mode codes; the unused codes behave as clamp.
   localparam logic [MODE_W-1:0] MODE_CLAMP     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PING_PONG = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REPEAT    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CYCLE     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MIRROR    = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_HIGH = 2'd2;

   // Per-transaction control that travels alongside the divider.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              neg;
      logic              pos;
      logic              err;
   } rww_side_type;

endpackage

// File: hw/rtl/rww_divider.sv
// Pipelined restoring divider giving the integer and 16 fraction bits of n / d.
module rww_divider import rww_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic [VALUE_WIDTH:0]                    in_dividend,
   input  logic [VALUE_WIDTH-1:0]                  in_divisor,
   input  rww_side_type                            in_side,
   output logic                                    out_valid,
   output logic [VALUE_WIDTH+WEIGHT_FRAC:0]        out_quotient,
   output logic                                    out_rem_zero,
   output rww_side_type                            out_side
);

   localparam int VW = VALUE_WIDTH;
   localparam int QB = VALUE_WIDTH + 1 + WEIGHT_FRAC;

   // One quotient bit per stage; the dividend shifts out as the quotient shifts in.
   logic [QB-1:0]   vld_ff;
   logic [QB-1:0]   vld_in;
   logic [VW-1:0]   rem_ff  [QB];
   logic [VW-1:0]   rem_in  [QB];
   logic [QB-1:0]   quo_ff  [QB];
   logic [QB-1:0]   quo_in  [QB];
   logic [VW-1:0]   div_ff  [QB];
   rww_side_type    side_ff [QB];

   logic [QB-1:0]   src_vld;
   logic [VW-1:0]   src_rem [QB];
   logic [QB-1:0]   src_quo [QB];
   logic [VW-1:0]   src_div [QB];
   rww_side_type    src_side [QB];

   // Each stage takes its operands from the stage before it.
   always_comb begin
      src_vld[0]  = in_valid;
      src_rem[0]  = '0;
      src_quo[0]  = {in_dividend, {WEIGHT_FRAC{1'b0}}};
      src_div[0]  = in_divisor;
      src_side[0] = in_side;
      for (int i = 1; i < QB; i++) begin
         src_vld[i]  = vld_ff[i-1];
         src_rem[i]  = rem_ff[i-1];
         src_quo[i]  = quo_ff[i-1];
         src_div[i]  = div_ff[i-1];
         src_side[i] = side_ff[i-1];
      end
   end

   // Trial subtraction of the divisor in every stage.
   always_comb begin
      logic [VW:0] trial;
      logic [VW:0] diff;
      logic        ge;
      for (int i = 0; i < QB; i++) begin
         trial     = {src_rem[i], src_quo[i][QB-1]};
         diff      = trial - {1'b0, src_div[i]};
         ge        = (trial >= {1'b0, src_div[i]});
         vld_in[i] = src_vld[i];
         rem_in[i] = ge ? diff[VW-1:0] : trial[VW-1:0];
         quo_in[i] = {src_quo[i][QB-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QB; i++) begin
         rem_ff[i]  <= rem_in[i];
         quo_ff[i]  <= quo_in[i];
         div_ff[i]  <= src_div[i];
         side_ff[i] <= src_side[i];
      end
   end

   assign out_valid    = vld_ff[QB-1];
   assign out_quotient = quo_ff[QB-1];
   assign out_rem_zero = (rem_ff[QB-1] == '0);
   assign out_side     = side_ff[QB-1];

endmodule

// File: hw/rtl/range_wrap_weight_top.sv
// Top level of the range wrap weight block: configuration, pipeline and result formatting.
//
// One sample may be started in every clock cycle, and each transaction gives exactly one
// result, marked by rsp_valid for a single cycle. The bit-serial divider spends one pipeline
// stage on each of the VALUE_WIDTH + 17 quotient bits; two stages in front form the offset,
// span and divider operands, and two behind it apply the wrap mode and saturate the counts.
// busy is always low and results cannot be held off, so the receiver must take each one
// as it appears. Configuration should be changed only while no transaction is in flight.
module range_wrap_weight_top import rww_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_sample_value,
   output logic                          rsp_valid,
   output logic signed [WEIGHT_W-1:0]    rsp_weight_out,
   output logic signed [COUNT_W-1:0]     rsp_wrap_count,
   output logic signed [COUNT_W-1:0]     rsp_apex_count,
   output logic                          rsp_rising,
   output logic                          rsp_range_error,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [VALUE_WIDTH-1:0]        csr_write_data
);

   localparam int VW  = VALUE_WIDTH;
   localparam int QB  = VALUE_WIDTH + 1 + WEIGHT_FRAC;
   localparam int IW  = VALUE_WIDTH + 1;
   localparam int WW  = VALUE_WIDTH + 4;
   localparam int LAT = QB + 4;
   localparam logic [VW-1:0]        HIGH_RESET = VW'(1) << FRAC_BITS;
   localparam logic signed [WW-1:0] CNT_MAX    = WW'(COUNT_MAX);
   localparam logic signed [WW-1:0] CNT_MIN    = ~CNT_MAX;

   // Configuration registers.
   logic [MODE_W-1:0] mode_ff;
   logic [VW-1:0]     low_ff;
   logic [VW-1:0]     high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CLAMP;
         low_ff  <= '0;
         high_ff <= HIGH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WRAP_MODE:  mode_ff <= csr_write_data[MODE_W-1:0];
            CSR_RANGE_LOW:  low_ff  <= csr_write_data;
            CSR_RANGE_HIGH: high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Stage A: offset of the sample and span of the range.
   logic                 sa_vld_ff;
   logic signed [VW:0]   sa_off_ff;
   logic signed [VW:0]   sa_span_ff;
   logic [MODE_W-1:0]    sa_mode_ff;
   logic signed [VW:0]   sa_off_in;
   logic signed [VW:0]   sa_span_in;

   assign sa_off_in  = {req_sample_value[VW-1], req_sample_value} - {low_ff[VW-1], low_ff};
   assign sa_span_in = {high_ff[VW-1], high_ff} - {low_ff[VW-1], low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff <= 1'b0;
      end else begin
         sa_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      sa_off_ff  <= sa_off_in;
      sa_span_ff <= sa_span_in;
      sa_mode_ff <= mode_ff;
   end

   // Stage B: magnitude, sign and range check.
   logic                 sb_vld_ff;
   logic [VW:0]          sb_n_ff;
   logic [VW-1:0]        sb_d_ff;
   rww_side_type         sb_side_ff;
   logic [VW:0]          sb_n_in;
   logic [VW-1:0]        sb_d_in;
   rww_side_type         sb_side_in;

   always_comb begin
      sb_side_in.mode = sa_mode_ff;
      sb_side_in.neg  = sa_off_ff[VW];
      sb_side_in.pos  = !sa_off_ff[VW] && (sa_off_ff != '0);
      sb_side_in.err  = sa_span_ff[VW] || (sa_span_ff == '0);
      sb_n_in         = sa_off_ff[VW] ? (VW+1)'(0) - sa_off_ff : sa_off_ff;
      // An invalid span still feeds the divider a defined, non-zero divisor.
      sb_d_in         = sb_side_in.err ? VW'(1) : sa_span_ff[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_vld_ff <= 1'b0;
      end else begin
         sb_vld_ff <= sa_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sb_n_ff    <= sb_n_in;
      sb_d_ff    <= sb_d_in;
      sb_side_ff <= sb_side_in;
   end

   // Divider pipeline.
   logic            dv_valid;
   logic [QB-1:0]   dv_quotient;
   logic            dv_rem_zero;
   rww_side_type    dv_side;

   rww_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (sb_vld_ff),
      .in_dividend  (sb_n_ff),
      .in_divisor   (sb_d_ff),
      .in_side      (sb_side_ff),
      .out_valid    (dv_valid),
      .out_quotient (dv_quotient),
      .out_rem_zero (dv_rem_zero),
      .out_side     (dv_side)
   );

   // Stage C: apply the wrap mode to the integer and fraction parts.
   logic                        sc_vld_ff;
   logic signed [WEIGHT_W-1:0]  sc_weight_ff;
   logic signed [WW-1:0]        sc_wrap_ff;
   logic signed [WW-1:0]        sc_apex_ff;
   logic                        sc_rising_ff;
   logic                        sc_err_ff;
   logic signed [WEIGHT_W-1:0]  sc_weight_in;
   logic signed [WW-1:0]        sc_wrap_in;
   logic signed [WW-1:0]        sc_apex_in;
   logic                        sc_rising_in;

   always_comb begin
      logic [IW-1:0]              qint;
      logic signed [WEIGHT_W-1:0] fx;
      logic signed [WW-1:0]       qx;
      logic signed [WW-1:0]       half_x;
      logic signed [WW-1:0]       quarter_x;
      logic signed [WW-1:0]       bit_x;
      logic signed [WW-1:0]       hv;
      logic signed [WEIGHT_W-1:0] mag;
      logic                       rnz;
      logic                       mz;
      logic [1:0]                 q2;

      qint      = dv_quotient[QB-1:WEIGHT_FRAC];
      fx        = {2'b00, dv_quotient[WEIGHT_FRAC-1:0]};
      qx        = $signed({3'b000, qint});
      half_x    = $signed({4'b0000, qint[IW-1:1]});
      quarter_x = $signed({5'b00000, qint[IW-1:2]});
      bit_x     = $signed({{(WW-1){1'b0}}, qint[0]});
      rnz       = (fx != '0) || !dv_rem_zero;
      q2        = qint[1:0];
      mz        = (q2 == 2'd0) && !rnz;

      sc_weight_in = '0;
      sc_wrap_in   = '0;
      sc_apex_in   = '0;
      sc_rising_in = 1'b0;
      hv           = '0;
      mag          = '0;

      if (!dv_side.err) begin
         case (dv_side.mode)
            MODE_PING_PONG: begin
               sc_wrap_in   = dv_side.neg ? -half_x : half_x;
               sc_apex_in   = (dv_side.neg ? -bit_x : bit_x)
                            + WW'(dv_side.pos && (qint[0] || rnz))
                            + (sc_wrap_in <<< 1);
               sc_rising_in = !qint[0];
               sc_weight_in = qint[0] ? WEIGHT_ONE - fx : fx;
            end
            MODE_REPEAT: begin
               sc_wrap_in   = dv_side.neg ? -qx : qx;
               sc_apex_in   = WW'(dv_side.pos) + sc_wrap_in;
               sc_rising_in = 1'b1;
               if (!dv_side.neg) begin
                  sc_weight_in = fx;
               end else begin
                  sc_weight_in = rnz ? WEIGHT_ONE - fx : '0;
               end
            end
            MODE_CYCLE: begin
               case (q2)
                  2'd0: begin hv = WW'(0); mag = fx;              end
                  2'd1: begin hv = WW'(1); mag = WEIGHT_ONE - fx; end
                  2'd2: begin hv = WW'(1); mag = -fx;             end
                  default: begin hv = WW'(2); mag = fx - WEIGHT_ONE; end
               endcase
               sc_wrap_in   = dv_side.neg ? -quarter_x : quarter_x;
               sc_rising_in = (q2 == 2'd0) || (q2 == 2'd3);
               if (mz) begin
                  sc_apex_in   = sc_wrap_in <<< 1;
                  sc_weight_in = '0;
               end else begin
                  sc_apex_in   = (dv_side.neg ? -hv : hv) + (sc_wrap_in <<< 1);
                  sc_weight_in = dv_side.neg ? -mag : mag;
               end
            end
            MODE_MIRROR: begin
               if (!dv_side.pos) begin
                  sc_rising_in = 1'b1;
               end else if (qint >= IW'(2)) begin
                  sc_wrap_in = WW'(1);
                  sc_apex_in = WW'(3);
               end else if (qint == '0) begin
                  sc_weight_in = fx;
                  sc_apex_in   = WW'(1);
                  sc_rising_in = 1'b1;
               end else begin
                  sc_weight_in = WEIGHT_ONE - fx;
                  sc_apex_in   = WW'(2);
               end
            end
            default: begin
               // Clamp, also taken by the unused mode codes.
               if (!dv_side.pos) begin
                  sc_rising_in = 1'b1;
               end else if (qint != '0) begin
                  sc_weight_in = WEIGHT_ONE;
                  sc_wrap_in   = WW'(1);
                  sc_apex_in   = WW'(2);
               end else begin
                  sc_weight_in = fx;
                  sc_apex_in   = WW'(1);
                  sc_rising_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_vld_ff <= 1'b0;
      end else begin
         sc_vld_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      sc_weight_ff <= sc_weight_in;
      sc_wrap_ff   <= sc_wrap_in;
      sc_apex_ff   <= sc_apex_in;
      sc_rising_ff <= sc_rising_in;
      sc_err_ff    <= dv_side.err;
   end

   // Stage D: saturate the counts and register the result transaction.
   logic                        rsp_valid_ff;
   logic signed [WEIGHT_W-1:0]  rsp_weight_ff;
   logic signed [COUNT_W-1:0]   rsp_wrap_ff;
   logic signed [COUNT_W-1:0]   rsp_apex_ff;
   logic                        rsp_rising_ff;
   logic                        rsp_err_ff;
   logic signed [COUNT_W-1:0]   rsp_wrap_in;
   logic signed [COUNT_W-1:0]   rsp_apex_in;

   always_comb begin
      if (sc_wrap_ff > CNT_MAX) begin
         rsp_wrap_in = CNT_MAX[COUNT_W-1:0];
      end else if (sc_wrap_ff < CNT_MIN) begin
         rsp_wrap_in = CNT_MIN[COUNT_W-1:0];
      end else begin
         rsp_wrap_in = sc_wrap_ff[COUNT_W-1:0];
      end
      if (sc_apex_ff > CNT_MAX) begin
         rsp_apex_in = CNT_MAX[COUNT_W-1:0];
      end else if (sc_apex_ff < CNT_MIN) begin
         rsp_apex_in = CNT_MIN[COUNT_W-1:0];
      end else begin
         rsp_apex_in = sc_apex_ff[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sc_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_weight_ff <= sc_weight_ff;
      rsp_wrap_ff   <= rsp_wrap_in;
      rsp_apex_ff   <= rsp_apex_in;
      rsp_rising_ff <= sc_rising_ff;
      rsp_err_ff    <= sc_err_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_weight_out  = rsp_weight_ff;
   assign rsp_wrap_count  = rsp_wrap_ff;
   assign rsp_apex_count  = rsp_apex_ff;
   assign rsp_rising      = rsp_rising_ff;
   assign rsp_range_error = rsp_err_ff;

   // Every started transaction gives its result after the fixed pipeline latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result missing after pipeline latency");

   // A range error leaves every other result field at zero.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |->
         (rsp_weight_out == '0 && rsp_wrap_count == '0 &&
          rsp_apex_count == '0 && !rsp_rising))
      else $error("range error result carries non-zero fields");

   // The weight stays within plus and minus one.
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weight_out <= WEIGHT_ONE && rsp_weight_out >= -WEIGHT_ONE))
      else $error("weight out of range");

endmodule
